// ----- rtl/core/cpt_pkg.sv -----
`timescale 1ns / 1ps
package cpt_pkg;

    localparam int CW   = 32;
    localparam int EW   = 33;
    localparam int PW1  = 66;
    localparam int DOTW = 67;
    localparam int MW   = 134;
    localparam int GW   = 136;
    localparam int SW   = 137;
    localparam int NDW  = 69;
    localparam int QW   = 17;
    localparam int ACW  = 52;
    localparam int SHW  = 36;

    localparam logic [QW-1:0] ONE_Q16 = 17'd65536;

endpackage

// ----- rtl/core/closest_point_on_triangle.sv -----
`timescale 1ns / 1ps
// Throughput is one word per cycle; the 17-stage restoring divider pipelines
// and the split 67-bit multipliers set the depth.
// A stalled output holds the whole pipeline, so the input is blocked as well.
// Synchronous active-low reset clears the valid bits only.
module closest_point_on_triangle
    import cpt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
    // corner2_x, corner2_y, corner2_z, query_x, query_y, query_z
    input  logic [383:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // near_x, near_y, near_z, weight_s, weight_t, six zero bits
    output logic [135:0] o_m_axis_tdata,
    // degenerate
    output logic         o_m_axis_tuser
);

    localparam int NST = 30;

    logic             r_vld [1:NST];
    logic             r_en;

    logic signed [CW-1:0]   w_in [12];
    logic signed [CW-1:0]   r1_c0 [3];
    logic signed [EW-1:0]   r1_u [3];
    logic signed [EW-1:0]   r1_v [3];
    logic signed [EW-1:0]   r1_w [3];

    logic signed [PW1-1:0]  r2_uu [3];
    logic signed [PW1-1:0]  r2_uv [3];
    logic signed [PW1-1:0]  r2_vv [3];
    logic signed [PW1-1:0]  r2_uw [3];
    logic signed [PW1-1:0]  r2_vw [3];

    logic signed [DOTW-1:0] r3_uu, r3_uv, r3_vv, r3_uw, r3_vw;
    logic signed [MW-1:0]   w_m_uuvv, w_m_uvuv, w_m_uvvw, w_m_vvuw, w_m_uvuw, w_m_uuvw;
    logic [5*DOTW-1:0]      w_dots;
    logic signed [DOTW-1:0] w_d_uu, w_d_uv, w_d_vv, w_d_uw, w_d_vw;

    logic signed [GW-1:0]   r8_g, r8_sn, r8_tn;
    logic signed [NDW-1:0]  r8_nk, r8_dk;
    logic                   r8_cv, r8_cu;
    logic signed [DOTW-1:0] r8_uu, r8_vv, r8_uw, r8_vw;

    logic signed [SW-1:0]   w_sum;
    logic                   w_lt;
    logic                   w_s_uw, w_s_g, w_s_nd, w_t_vw, w_t_g, w_t_om;
    logic signed [GW-1:0]   w_ns, w_ds, w_nt, w_dt;
    logic signed [GW-1:0]   r9_ns, r9_ds, r9_nt, r9_dt;
    logic                   r9_oms;

    logic [QW-1:0]          w_qs, w_qt;
    logic                   w_dzs, w_dzt, w_oms;
    logic [QW-1:0]          r27_ws, r27_wt;
    logic                   r27_dg;

    logic [6*EW-1:0]        w_uv_d;
    logic [3*CW-1:0]        w_c0_d;
    logic signed [EW-1:0]   w_u27 [3];
    logic signed [EW-1:0]   w_v27 [3];
    logic signed [CW-1:0]   w_c028 [3];
    logic signed [EW+QW:0]  r28_ps [3];
    logic signed [EW+QW:0]  r28_pt [3];
    logic [2*QW:0]          w_wd;
    logic signed [ACW-1:0]  r29_acc [3];
    logic signed [SHW-1:0]  w_sh [3];
    logic [CW-1:0]          r30_p [3];
    logic [QW-1:0]          r30_ws, r30_wt;
    logic                   r30_dg;

    assign r_en            = !r_vld[NST] || i_m_axis_tready;
    assign o_s_axis_tready = r_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (r_en) begin
            r_vld[1] <= i_s_axis_tvalid;
            for (int k = 2; k <= NST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 12; k++) begin
            w_in[k] = $signed(i_s_axis_tdata[CW*k +: CW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_c0[k] <= w_in[k];
                r1_u[k]  <= EW'(w_in[3+k]) - EW'(w_in[k]);
                r1_v[k]  <= EW'(w_in[6+k]) - EW'(w_in[k]);
                r1_w[k]  <= EW'(w_in[k]) - EW'(w_in[9+k]);
                r2_uu[k] <= r1_u[k] * r1_u[k];
                r2_uv[k] <= r1_u[k] * r1_v[k];
                r2_vv[k] <= r1_v[k] * r1_v[k];
                r2_uw[k] <= r1_u[k] * r1_w[k];
                r2_vw[k] <= r1_v[k] * r1_w[k];
            end
            r3_uu <= DOTW'(r2_uu[0]) + DOTW'(r2_uu[1]) + DOTW'(r2_uu[2]);
            r3_uv <= DOTW'(r2_uv[0]) + DOTW'(r2_uv[1]) + DOTW'(r2_uv[2]);
            r3_vv <= DOTW'(r2_vv[0]) + DOTW'(r2_vv[1]) + DOTW'(r2_vv[2]);
            r3_uw <= DOTW'(r2_uw[0]) + DOTW'(r2_uw[1]) + DOTW'(r2_uw[2]);
            r3_vw <= DOTW'(r2_vw[0]) + DOTW'(r2_vw[1]) + DOTW'(r2_vw[2]);
        end
    end

    cpt_mul #(.W(DOTW)) u_mul_uuvv (.i_clk, .i_en(r_en), .i_a(r3_uu), .i_b(r3_vv),
                                    .o_p(w_m_uuvv));
    cpt_mul #(.W(DOTW)) u_mul_uvuv (.i_clk, .i_en(r_en), .i_a(r3_uv), .i_b(r3_uv),
                                    .o_p(w_m_uvuv));
    cpt_mul #(.W(DOTW)) u_mul_uvvw (.i_clk, .i_en(r_en), .i_a(r3_uv), .i_b(r3_vw),
                                    .o_p(w_m_uvvw));
    cpt_mul #(.W(DOTW)) u_mul_vvuw (.i_clk, .i_en(r_en), .i_a(r3_vv), .i_b(r3_uw),
                                    .o_p(w_m_vvuw));
    cpt_mul #(.W(DOTW)) u_mul_uvuw (.i_clk, .i_en(r_en), .i_a(r3_uv), .i_b(r3_uw),
                                    .o_p(w_m_uvuw));
    cpt_mul #(.W(DOTW)) u_mul_uuvw (.i_clk, .i_en(r_en), .i_a(r3_uu), .i_b(r3_vw),
                                    .o_p(w_m_uuvw));

    cpt_dly #(.W(5*DOTW), .N(4)) u_dly_dots (
        .i_clk,
        .i_en (r_en),
        .i_d  ({r3_uu, r3_uv, r3_vv, r3_uw, r3_vw}),
        .o_q  (w_dots)
    );

    assign w_d_uu = $signed(w_dots[5*DOTW-1:4*DOTW]);
    assign w_d_uv = $signed(w_dots[4*DOTW-1:3*DOTW]);
    assign w_d_vv = $signed(w_dots[3*DOTW-1:2*DOTW]);
    assign w_d_uw = $signed(w_dots[2*DOTW-1:DOTW]);
    assign w_d_vw = $signed(w_dots[DOTW-1:0]);

    always_ff @(posedge i_clk) begin
        if (r_en) begin
            r8_g  <= GW'(w_m_uuvv) - GW'(w_m_uvuv);
            r8_sn <= GW'(w_m_uvvw) - GW'(w_m_vvuw);
            r8_tn <= GW'(w_m_uvuw) - GW'(w_m_uuvw);
            r8_nk <= NDW'(w_d_vv) + NDW'(w_d_vw) - NDW'(w_d_uv) - NDW'(w_d_uw);
            r8_dk <= NDW'(w_d_uu) + NDW'(w_d_vv) - NDW'(w_d_uv) - NDW'(w_d_uv);
            r8_cv <= (NDW'(w_d_vv) + NDW'(w_d_vw)) > (NDW'(w_d_uv) + NDW'(w_d_uw));
            r8_cu <= (NDW'(w_d_uu) + NDW'(w_d_uw)) > (NDW'(w_d_uv) + NDW'(w_d_vw));
            r8_uu <= w_d_uu;
            r8_vv <= w_d_vv;
            r8_uw <= w_d_uw;
            r8_vw <= w_d_vw;
        end
    end

    always_comb begin
        w_sum  = SW'(r8_sn) + SW'(r8_tn);
        w_lt   = w_sum < SW'(r8_g);
        w_s_uw = 1'b0;
        w_s_g  = 1'b0;
        w_s_nd = 1'b0;
        w_t_vw = 1'b0;
        w_t_g  = 1'b0;
        w_t_om = 1'b0;
        if (w_lt) begin
            if (r8_sn < 0) begin
                if (r8_tn < 0 && r8_uw < 0) begin
                    w_s_uw = 1'b1;
                end else begin
                    w_t_vw = 1'b1;
                end
            end else if (r8_tn < 0) begin
                w_s_uw = 1'b1;
            end else begin
                w_s_g = 1'b1;
                w_t_g = 1'b1;
            end
        end else if (r8_sn < 0) begin
            if (r8_cv) begin
                w_s_nd = 1'b1;
                w_t_om = 1'b1;
            end else begin
                w_t_vw = 1'b1;
            end
        end else if (r8_tn < 0) begin
            if (r8_cu) begin
                w_s_nd = 1'b1;
                w_t_om = 1'b1;
            end else begin
                w_s_uw = 1'b1;
            end
        end else begin
            w_s_nd = 1'b1;
            w_t_om = 1'b1;
        end

        if (w_s_uw) begin
            w_ns = -GW'(r8_uw);
            w_ds = GW'(r8_uu);
        end else if (w_s_g) begin
            w_ns = r8_sn;
            w_ds = r8_g;
        end else if (w_s_nd) begin
            w_ns = GW'(r8_nk);
            w_ds = GW'(r8_dk);
        end else begin
            w_ns = '0;
            w_ds = GW'(1);
        end

        if (w_t_vw) begin
            w_nt = -GW'(r8_vw);
            w_dt = GW'(r8_vv);
        end else if (w_t_g) begin
            w_nt = r8_tn;
            w_dt = r8_g;
        end else begin
            w_nt = '0;
            w_dt = GW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_en) begin
            r9_ns  <= w_ns;
            r9_ds  <= w_ds;
            r9_nt  <= w_nt;
            r9_dt  <= w_dt;
            r9_oms <= w_t_om;
        end
    end

    cpt_div #(.W(GW)) u_div_s (
        .i_clk,
        .i_en  (r_en),
        .i_num (r9_ns),
        .i_den (r9_ds),
        .o_q   (w_qs),
        .o_dz  (w_dzs)
    );

    cpt_div #(.W(GW)) u_div_t (
        .i_clk,
        .i_en  (r_en),
        .i_num (r9_nt),
        .i_den (r9_dt),
        .o_q   (w_qt),
        .o_dz  (w_dzt)
    );

    cpt_dly #(.W(1), .N(17)) u_dly_oms (
        .i_clk,
        .i_en (r_en),
        .i_d  (r9_oms),
        .o_q  (w_oms)
    );

    always_ff @(posedge i_clk) begin
        if (r_en) begin
            r27_ws <= w_qs;
            r27_wt <= w_oms ? ONE_Q16 - w_qs : w_qt;
            r27_dg <= w_dzs || w_dzt;
        end
    end

    cpt_dly #(.W(6*EW), .N(26)) u_dly_uv (
        .i_clk,
        .i_en (r_en),
        .i_d  ({r1_v[2], r1_v[1], r1_v[0], r1_u[2], r1_u[1], r1_u[0]}),
        .o_q  (w_uv_d)
    );

    cpt_dly #(.W(3*CW), .N(27)) u_dly_c0 (
        .i_clk,
        .i_en (r_en),
        .i_d  ({r1_c0[2], r1_c0[1], r1_c0[0]}),
        .o_q  (w_c0_d)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_u27[k]  = $signed(w_uv_d[EW*k +: EW]);
            w_v27[k]  = $signed(w_uv_d[EW*(k+3) +: EW]);
            w_c028[k] = $signed(w_c0_d[CW*k +: CW]);
        end
    end

    cpt_dly #(.W(2*QW+1), .N(2)) u_dly_w (
        .i_clk,
        .i_en (r_en),
        .i_d  ({r27_dg, r27_wt, r27_ws}),
        .o_q  (w_wd)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sh[k] = r29_acc[k][ACW-1:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_en) begin
            for (int k = 0; k < 3; k++) begin
                r28_ps[k]  <= w_u27[k] * $signed({1'b0, r27_ws});
                r28_pt[k]  <= w_v27[k] * $signed({1'b0, r27_wt});
                r29_acc[k] <= (ACW'(w_c028[k]) <<< 16) + ACW'(r28_ps[k]) + ACW'(r28_pt[k])
                              + ACW'(32768);
                if (w_sh[k] > SHW'(32'sh7FFFFFFF)) begin
                    r30_p[k] <= 32'h7FFFFFFF;
                end else if (w_sh[k] < -SHW'(33'sh080000000)) begin
                    r30_p[k] <= 32'h80000000;
                end else begin
                    r30_p[k] <= w_sh[k][CW-1:0];
                end
            end
            r30_ws <= w_wd[QW-1:0];
            r30_wt <= w_wd[2*QW-1:QW];
            r30_dg <= w_wd[2*QW];
        end
    end

    assign o_m_axis_tvalid = r_vld[NST];
    assign o_m_axis_tdata  = {6'b0, r30_wt, r30_ws, r30_p[2], r30_p[1], r30_p[0]};
    assign o_m_axis_tuser  = r30_dg;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_vld[1])
        else $error("accepted word did not enter the pipeline");

    a_weights_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((18'(r30_ws) + 18'(r30_wt)) <= 18'(ONE_Q16)))
        else $error("weights add up to more than one");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_en |-> (!o_s_axis_tready && o_m_axis_tvalid))
        else $error("pipeline stalled without a waiting output word");

endmodule

// ----- rtl/core/cpt_dly.sv -----
`timescale 1ns / 1ps
module cpt_dly
    import cpt_pkg::*;
#(
    parameter int W = CW,
    parameter int N = 2
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_sr [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_q = r_sr[N-1];

endmodule

// ----- rtl/core/cpt_mul.sv -----
`timescale 1ns / 1ps
module cpt_mul
    import cpt_pkg::*;
#(
    parameter int W = DOTW
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_p
);

    localparam int H  = (W + 1) / 2;
    localparam int HW = W - H;
    localparam int PW = 2 * W;

    logic [2:0]        r_sg;
    logic [W-1:0]      r_ma;
    logic [W-1:0]      r_mb;
    logic [2*H-1:0]    r_ll;
    logic [H+HW-1:0]   r_lh;
    logic [H+HW-1:0]   r_hl;
    logic [2*HW-1:0]   r_hh;
    logic [PW-1:0]     r_sum;
    logic signed [PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sg[0] <= i_a[W-1] ^ i_b[W-1];
            r_ma    <= i_a[W-1] ? W'(-i_a) : W'(i_a);
            r_mb    <= i_b[W-1] ? W'(-i_b) : W'(i_b);
            r_sg[1] <= r_sg[0];
            r_ll    <= r_ma[H-1:0] * r_mb[H-1:0];
            r_lh    <= r_ma[H-1:0] * r_mb[W-1:H];
            r_hl    <= r_ma[W-1:H] * r_mb[H-1:0];
            r_hh    <= r_ma[W-1:H] * r_mb[W-1:H];
            r_sg[2] <= r_sg[1];
            r_sum   <= (PW'(r_hh) << (2 * H)) + ((PW'(r_lh) + PW'(r_hl)) << H)
                       + PW'(r_ll);
            r_p     <= $signed(r_sg[2] ? PW'(-r_sum) : r_sum);
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/cpt_div.sv -----
`timescale 1ns / 1ps
module cpt_div
    import cpt_pkg::*;
#(
    parameter int W = GW
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    output logic [QW-1:0]       o_q,
    output logic                o_dz
);

    localparam int NS = QW - 1;

    logic [W:0]      r_rem [NS+1];
    logic [W-1:0]    r_dd  [NS+1];
    logic [NS-1:0]   r_q   [NS+1];
    logic            r_fix [NS+1];
    logic [QW-1:0]   r_fq  [NS+1];
    logic            r_dz  [NS+1];
    logic [W:0]      w_two [NS];
    logic            w_ge  [NS];

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            w_two[k] = {r_rem[k][W-1:0], 1'b0};
            w_ge[k]  = w_two[k] >= {1'b0, r_dd[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, i_num};
            r_dd[0]  <= i_den;
            r_q[0]   <= '0;
            r_dz[0]  <= (i_den == '0);
            if (i_den == '0 || i_den < 0 || i_num <= 0) begin
                r_fix[0] <= 1'b1;
                r_fq[0]  <= '0;
            end else if (i_num >= i_den) begin
                r_fix[0] <= 1'b1;
                r_fq[0]  <= ONE_Q16;
            end else begin
                r_fix[0] <= 1'b0;
                r_fq[0]  <= '0;
            end
            for (int k = 0; k < NS; k++) begin
                r_rem[k+1] <= w_ge[k] ? w_two[k] - {1'b0, r_dd[k]} : w_two[k];
                r_q[k+1]   <= {r_q[k][NS-2:0], w_ge[k]};
                r_dd[k+1]  <= r_dd[k];
                r_fix[k+1] <= r_fix[k];
                r_fq[k+1]  <= r_fq[k];
                r_dz[k+1]  <= r_dz[k];
            end
        end
    end

    assign o_q  = r_fix[NS] ? r_fq[NS] : {1'b0, r_q[NS]};
    assign o_dz = r_dz[NS];

endmodule
